>>> hw/rtl/alpf_pkg.sv
// shared types, constants and helpers of the acceleration-limited position follower
package alpf_pkg;

    localparam int POS_W      = 32;
    localparam int MAG_W      = 31;
    localparam int DT_W       = 16;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int CNT_W      = 5;

    // last count of the shift-add and shift-subtract loops
    localparam logic [CNT_W-1:0] WIDE_LAST   = CNT_W'(MAG_W - 1);
    localparam logic [CNT_W-1:0] NARROW_LAST = CNT_W'(DT_W - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK         = 2'd0,
        CMD_SET_TARGET   = 2'd1,
        CMD_SET_POSITION = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOWDOWN_DIST  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TOL     = 3'd5;

    localparam logic signed [POS_W-1:0] RST_TARGET_MIN     = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0] RST_TARGET_MAX     = 32'sh7FFF_FFFF;
    localparam logic [MAG_W-1:0]        RST_VELOCITY_LIMIT = 31'd655360;
    localparam logic [MAG_W-1:0]        RST_SLOWDOWN_DIST  = 31'd131072;
    localparam logic [MAG_W-1:0]        RST_ACCELERATION   = 31'd65536;
    localparam logic [MAG_W-1:0]        RST_ARRIVE_TOL     = 31'd6554;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_CHECK     = 10'b00_0000_0010,
        ST_MUL_WANT  = 10'b00_0000_0100,
        ST_DIVIDE    = 10'b00_0000_1000,
        ST_MUL_DV    = 10'b00_0001_0000,
        ST_RAMP      = 10'b00_0010_0000,
        ST_PREP_STEP = 10'b00_0100_0000,
        ST_MUL_STEP  = 10'b00_1000_0000,
        ST_MOVE      = 10'b01_0000_0000,
        ST_DONE      = 10'b10_0000_0000
    } state_t;

    // |a - b| of two signed words, never overflows 33 bits
    function automatic logic [POS_W:0] abs_diff(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic [POS_W:0] d_ab;
        logic [POS_W:0] d_ba;
        d_ab = {a[POS_W-1], a} - {b[POS_W-1], b};
        d_ba = {b[POS_W-1], b} - {a[POS_W-1], a};
        return d_ab[POS_W] ? d_ba : d_ab;
    endfunction

endpackage

>>> hw/rtl/accel_limited_position_follower_core.sv
// top level of the acceleration-limited position follower, bit-serial datapath
//
// input channel: in_valid / in_stall with cmd, elapsed, operand_value; one beat
// per command. output channel: out_valid / out_stall with position, speed,
// distance and reached; exactly one beat per input beat, in order.
// configuration: cfg_write with cfg_index / cfg_data, taken at any edge; the user
// must see that it is only written while the block is idle, the block does not
// enforce this. indexes beyond the register list are ignored. set commands,
// unused commands and ticks with zero elapsed time go straight to the done
// state and give their result beat from there. a tick that moves runs one
// shift-add unit over the 31-bit wanted-speed product, a restoring divider that
// yields one quotient bit per cycle, then two shift-adds over elapsed; a tick
// at or beyond the slowdown distance skips the product and the divide. an
// arrived tick goes from the check straight to the done state. one command is
// in work at a time; in_stall is low only while the sequencer is idle, and a
// finished beat may wait in the output register while the next command is
// already accepted. if the receiver stalls, the output beat holds and the next
// finished result waits in the sequencer until the register frees.
// reset (rst_n low, asynchronous) clears position, target and velocity, loads
// the register defaults and empties the output register.
module accel_limited_position_follower_core
    import alpf_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [CMD_W-1:0]             cmd,
    input  logic [DT_W-1:0]              elapsed,
    input  logic signed [POS_W-1:0]      operand_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [POS_W-1:0]      position,
    output logic signed [POS_W-1:0]      speed,
    output logic [MAG_W-1:0]             distance,
    output logic                         reached,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam logic signed [POS_W+1:0] SAT_HI = 34'sd2147483647;
    localparam logic signed [POS_W+1:0] SAT_LO = -34'sd2147483648;

    state_t state_reg, state_next;

    logic signed [POS_W-1:0] target_min_reg, target_min_next;
    logic signed [POS_W-1:0] target_max_reg, target_max_next;
    logic [MAG_W-1:0]        vlimit_reg, vlimit_next;
    logic [MAG_W-1:0]        slowdown_reg, slowdown_next;
    logic [MAG_W-1:0]        accel_reg, accel_next;
    logic [MAG_W-1:0]        tol_reg, tol_next;

    logic signed [POS_W-1:0] position_reg, position_next;
    logic signed [POS_W-1:0] target_reg, target_next;
    logic signed [POS_W-1:0] velocity_reg, velocity_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        hi_reg, hi_next;
    logic [MAG_W-1:0]        lo_reg, lo_next;
    logic [POS_W-1:0]        mcand_reg, mcand_next;
    logic [MAG_W-1:0]        wmag_reg, wmag_next;
    logic [DT_W-1:0]         dt_reg, dt_next;
    logic                    neg_reg, neg_next;

    logic                    out_valid_reg, out_valid_next;
    logic signed [POS_W-1:0] out_position_reg, out_position_next;
    logic signed [POS_W-1:0] out_speed_reg, out_speed_next;
    logic [MAG_W-1:0]        out_distance_reg, out_distance_next;
    logic                    out_reached_reg, out_reached_next;

    logic                    in_accept;
    logic [POS_W:0]          gap;
    logic [POS_W:0]          mul_sum;
    logic [POS_W-1:0]        div_trial;
    logic                    div_ge;
    logic [POS_W-1:0]        div_rem;
    logic signed [POS_W+1:0] ramp_wanted;
    logic signed [POS_W+1:0] ramp_vel;
    logic signed [POS_W+1:0] ramp_dv;
    logic signed [POS_W+1:0] ramp_up;
    logic signed [POS_W+1:0] ramp_dn;
    logic signed [POS_W+1:0] ramp_new;
    logic signed [POS_W+1:0] move_step;
    logic signed [POS_W+1:0] move_sum;
    logic signed [POS_W+1:0] move_sat;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign position  = out_position_reg;
    assign speed     = out_speed_reg;
    assign distance  = out_distance_reg;
    assign reached   = out_reached_reg;

    // distance between target and position, used by the arrival test and the report
    assign gap = abs_diff(target_reg, position_reg);

    // one shift-add step: add the multiplicand when the low multiplier bit is set
    assign mul_sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);

    // one restoring divide step: partial remainder sits in hi, quotient shifts into lo
    assign div_trial = {hi_reg[MAG_W-1:0], lo_reg[MAG_W-1]};
    assign div_ge    = (div_trial >= {1'b0, slowdown_reg});
    assign div_rem   = div_ge ? (div_trial - {1'b0, slowdown_reg}) : div_trial;

    // velocity ramp toward the wanted speed, clamped so it never passes it
    always_comb
    begin
        ramp_wanted = neg_reg ? -$signed({3'b000, wmag_reg}) : $signed({3'b000, wmag_reg});
        ramp_vel    = {{2{velocity_reg[POS_W-1]}}, velocity_reg};
        ramp_dv     = $signed({3'b000, hi_reg[MAG_W-1:0]});
        ramp_up     = ramp_vel + ramp_dv;
        ramp_dn     = ramp_vel - ramp_dv;
        if (ramp_vel < ramp_wanted)
        begin
            ramp_new = (ramp_up > ramp_wanted) ? ramp_wanted : ramp_up;
        end
        else
        begin
            ramp_new = (ramp_dn < ramp_wanted) ? ramp_wanted : ramp_dn;
        end
    end

    // position advance by the truncated step, saturated to the word
    always_comb
    begin
        move_step = velocity_reg[POS_W-1] ? -$signed({2'b00, hi_reg})
                                          : $signed({2'b00, hi_reg});
        move_sum  = {{2{position_reg[POS_W-1]}}, position_reg} + move_step;
        priority if (move_sum > SAT_HI)
        begin
            move_sat = SAT_HI;
        end
        else if (move_sum < SAT_LO)
        begin
            move_sat = SAT_LO;
        end
        else
        begin
            move_sat = move_sum;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        target_min_next   = target_min_reg;
        target_max_next   = target_max_reg;
        vlimit_next       = vlimit_reg;
        slowdown_next     = slowdown_reg;
        accel_next        = accel_reg;
        tol_next          = tol_reg;
        position_next     = position_reg;
        target_next       = target_reg;
        velocity_next     = velocity_reg;
        count_next        = count_reg;
        hi_next           = hi_reg;
        lo_next           = lo_reg;
        mcand_next        = mcand_reg;
        wmag_next         = wmag_reg;
        dt_next           = dt_reg;
        neg_next          = neg_reg;
        out_valid_next    = out_valid_reg;
        out_position_next = out_position_reg;
        out_speed_next    = out_speed_reg;
        out_distance_next = out_distance_reg;
        out_reached_next  = out_reached_reg;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TARGET_MIN:     target_min_next = $signed(cfg_data);
                REG_TARGET_MAX:     target_max_next = $signed(cfg_data);
                REG_VELOCITY_LIMIT: vlimit_next     = cfg_data[MAG_W-1:0];
                REG_SLOWDOWN_DIST:  slowdown_next   = cfg_data[MAG_W-1:0];
                REG_ACCELERATION:   accel_next      = cfg_data[MAG_W-1:0];
                REG_ARRIVE_TOL:     tol_next        = cfg_data[MAG_W-1:0];
                default:            ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DONE;
                    unique case (cmd_t'(cmd))
                        CMD_TICK:
                        begin
                            dt_next = elapsed;
                            if (elapsed != '0)
                            begin
                                state_next = ST_CHECK;
                            end
                        end
                        CMD_SET_TARGET:
                        begin
                            priority if (operand_value > target_max_reg)
                            begin
                                target_next = target_max_reg;
                            end
                            else if (operand_value < target_min_reg)
                            begin
                                target_next = target_min_reg;
                            end
                            else
                            begin
                                target_next = operand_value;
                            end
                        end
                        CMD_SET_POSITION:
                        begin
                            position_next = operand_value;
                            target_next   = operand_value;
                            velocity_next = '0;
                        end
                        default: ;
                    endcase
                end
            end

            ST_CHECK:
            begin
                neg_next = (target_reg < position_reg);
                priority if (gap <= {2'b00, tol_reg})
                begin
                    velocity_next = '0;
                    state_next    = ST_DONE;
                end
                else if (gap >= {2'b00, slowdown_reg})
                begin
                    // far side of the slowdown distance: full speed wanted
                    wmag_next  = vlimit_reg;
                    mcand_next = {1'b0, accel_reg};
                    hi_next    = '0;
                    lo_next    = {{(MAG_W-DT_W){1'b0}}, dt_reg};
                    count_next = NARROW_LAST;
                    state_next = ST_MUL_DV;
                end
                else
                begin
                    mcand_next = {1'b0, vlimit_reg};
                    hi_next    = '0;
                    lo_next    = gap[MAG_W-1:0];
                    count_next = WIDE_LAST;
                    state_next = ST_MUL_WANT;
                end
            end

            ST_MUL_WANT:
            begin
                hi_next    = mul_sum[POS_W:1];
                lo_next    = {mul_sum[0], lo_reg[MAG_W-1:1]};
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    // product upper half is below the divisor, so it seeds the remainder
                    count_next = WIDE_LAST;
                    state_next = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                hi_next    = div_rem;
                lo_next    = {lo_reg[MAG_W-2:0], div_ge};
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    wmag_next  = {lo_reg[MAG_W-2:0], div_ge};
                    mcand_next = {1'b0, accel_reg};
                    hi_next    = '0;
                    lo_next    = {{(MAG_W-DT_W){1'b0}}, dt_reg};
                    count_next = NARROW_LAST;
                    state_next = ST_MUL_DV;
                end
            end

            ST_MUL_DV:
            begin
                hi_next    = mul_sum[POS_W:1];
                lo_next    = {mul_sum[0], lo_reg[MAG_W-1:1]};
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_RAMP;
                end
            end

            ST_RAMP:
            begin
                velocity_next = ramp_new[POS_W-1:0];
                state_next    = ST_PREP_STEP;
            end

            ST_PREP_STEP:
            begin
                mcand_next = velocity_reg[POS_W-1] ? (~velocity_reg + 1'b1) : velocity_reg;
                hi_next    = '0;
                lo_next    = {{(MAG_W-DT_W){1'b0}}, dt_reg};
                count_next = NARROW_LAST;
                state_next = ST_MUL_STEP;
            end

            ST_MUL_STEP:
            begin
                hi_next    = mul_sum[POS_W:1];
                lo_next    = {mul_sum[0], lo_reg[MAG_W-1:1]};
                count_next = count_reg - 1'b1;
                if (count_reg == '0)
                begin
                    state_next = ST_MOVE;
                end
            end

            ST_MOVE:
            begin
                position_next = move_sat[POS_W-1:0];
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                // wait here while the output register still holds a stalled beat
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next    = 1'b1;
                    out_position_next = position_reg;
                    out_speed_next    = velocity_reg;
                    out_distance_next = gap[POS_W:MAG_W] != '0 ? {MAG_W{1'b1}}
                                                                : gap[MAG_W-1:0];
                    out_reached_next  = (gap <= {2'b00, tol_reg});
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            target_min_reg <= RST_TARGET_MIN;
            target_max_reg <= RST_TARGET_MAX;
            vlimit_reg     <= RST_VELOCITY_LIMIT;
            slowdown_reg   <= RST_SLOWDOWN_DIST;
            accel_reg      <= RST_ACCELERATION;
            tol_reg        <= RST_ARRIVE_TOL;
            position_reg   <= '0;
            target_reg     <= '0;
            velocity_reg   <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            target_min_reg <= target_min_next;
            target_max_reg <= target_max_next;
            vlimit_reg     <= vlimit_next;
            slowdown_reg   <= slowdown_next;
            accel_reg      <= accel_next;
            tol_reg        <= tol_next;
            position_reg   <= position_next;
            target_reg     <= target_next;
            velocity_reg   <= velocity_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg           <= hi_next;
        lo_reg           <= lo_next;
        mcand_reg        <= mcand_next;
        wmag_reg         <= wmag_next;
        dt_reg           <= dt_next;
        neg_reg          <= neg_next;
        out_position_reg <= out_position_next;
        out_speed_reg    <= out_speed_next;
        out_distance_reg <= out_distance_next;
        out_reached_reg  <= out_reached_next;
    end

endmodule

>>> tb/tb.sv
// testbench for the acceleration-limited position follower core
`timescale 1ns / 100ps

module tb;
    import alpf_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int RAND_ITEMS = 1950;
    localparam int PHASES     = 7;

    localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;
    localparam logic [MAG_W-1:0]     MAG_TOP     = 31'h7FFF_FFFF;
    localparam longint               POS_TOP     = 2147483647;
    localparam longint               POS_BOTTOM  = -POS_TOP - 1;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] speed;
        logic [MAG_W-1:0]        distance;
        logic                    reached;
    } motion_beat_t;

    class follower_scoreboard;
        logic signed [POS_W-1:0] tgt_lo, tgt_hi;
        logic [MAG_W-1:0]        vlim, slow_dist, accel, tol;
        logic signed [POS_W-1:0] pos, tgt, vel;
        motion_beat_t            expected_q[$];
        int                      errors;

        function new();
            tgt_lo    = RST_TARGET_MIN;
            tgt_hi    = RST_TARGET_MAX;
            vlim      = RST_VELOCITY_LIMIT;
            slow_dist = RST_SLOWDOWN_DIST;
            accel     = RST_ACCELERATION;
            tol       = RST_ARRIVE_TOL;
            pos       = '0;
            tgt       = '0;
            vel       = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_MIN:     tgt_lo = data;
                REG_TARGET_MAX:     tgt_hi = data;
                REG_VELOCITY_LIMIT: vlim = data[MAG_W-1:0];
                REG_SLOWDOWN_DIST:  slow_dist = data[MAG_W-1:0];
                REG_ACCELERATION:   accel = data[MAG_W-1:0];
                REG_ARRIVE_TOL:     tol = data[MAG_W-1:0];
                default: ;
            endcase
        endfunction

        function void advance(logic [DT_W-1:0] dt);
            longint          diff, wanted, v, step, moved;
            longint unsigned gap, dv, pm, dt_w;
            dt_w = 64'(dt);
            if (dt_w == 0)
                return;
            diff = longint'(tgt) - longint'(pos);
            gap = (diff < 0) ? -diff : diff;
            if (gap <= tol)
            begin
                vel = '0;
                return;
            end
            // wanted speed is proportional to the distance left
            if (slow_dist == 0)
                gap = 64'(vlim);
            else
            begin
                gap = (gap * vlim) / slow_dist;
                if (gap > vlim)
                    gap = 64'(vlim);
            end
            wanted = (diff < 0) ? -longint'(gap) : longint'(gap);
            dv = (dt_w * accel) >> 16;
            v = vel;
            if (v < wanted)
            begin
                v = v + longint'(dv);
                if (v > wanted)
                    v = wanted;
            end
            else
            begin
                v = v - longint'(dv);
                if (v < wanted)
                    v = wanted;
            end
            vel = v[POS_W-1:0];
            pm = (v < 0) ? -v : v;
            pm = (pm * dt_w) / 65536;
            step = (v < 0) ? -longint'(pm) : longint'(pm);
            moved = longint'(pos) + step;
            if (moved > POS_TOP)
                moved = POS_TOP;
            else if (moved < POS_BOTTOM)
                moved = POS_BOTTOM;
            pos = moved[POS_W-1:0];
        endfunction

        function void note_beat(logic [CMD_W-1:0] c, logic [DT_W-1:0] dt,
                                logic signed [POS_W-1:0] opv);
            motion_beat_t    beat;
            longint          diff;
            longint unsigned gap;
            case (c)
                CMD_TICK: advance(dt);
                CMD_SET_TARGET:
                begin
                    // max is tested first so a crossed window gives target_max
                    if (opv > tgt_hi)
                        tgt = tgt_hi;
                    else if (opv < tgt_lo)
                        tgt = tgt_lo;
                    else
                        tgt = opv;
                end
                CMD_SET_POSITION:
                begin
                    pos = opv;
                    tgt = opv;
                    vel = '0;
                end
                default: ;
            endcase
            diff = longint'(tgt) - longint'(pos);
            gap = (diff < 0) ? -diff : diff;
            beat.position = pos;
            beat.speed    = vel;
            beat.distance = (gap > MAG_TOP) ? MAG_TOP : gap[MAG_W-1:0];
            beat.reached  = (gap <= tol);
            expected_q.push_back(beat);
        endfunction

        function void match(string what, logic signed [63:0] e, logic signed [63:0] a);
            if (a !== e)
            begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, what, e, a);
            end
        endfunction

        function void check_beat(logic signed [POS_W-1:0] p, logic signed [POS_W-1:0] s,
                                 logic [MAG_W-1:0] d, logic r);
            motion_beat_t exp_beat;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, position %0d speed %0d",
                         $time, p, s);
                return;
            end
            exp_beat = expected_q.pop_front();
            match("position", exp_beat.position, p);
            match("speed", exp_beat.speed, s);
            match("distance", exp_beat.distance, d);
            match("reached", exp_beat.reached, r);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CMD_W-1:0]        cmd = CMD_TICK;
    logic [DT_W-1:0]         elapsed = '0;
    logic signed [POS_W-1:0] operand_value = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] speed;
    logic [MAG_W-1:0]        distance;
    logic                    reached;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    follower_scoreboard sb = new();
    int burst_left = 0;
    int stall_mode = 0;
    int stall_win = 0;
    int idle_cycles = 0;

    accel_limited_position_follower_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .elapsed       (elapsed),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .position      (position),
        .speed         (speed),
        .distance      (distance),
        .reached       (reached),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls in windows: none, light, heavy or alternating
    always @(negedge clk)
    begin
        if (stall_win == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_win  = $urandom_range(16, 80);
        end
        stall_win--;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 3) == 0);
            2: out_stall = ($urandom_range(0, 3) != 0);
            default: out_stall = ~out_stall;
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(position, speed, distance, reached);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL accel_limited_position_follower_core");
                $finish;
            end
        end
    end

    // one input beat; called and returns at a falling edge
    task automatic issue(input logic [CMD_W-1:0] c, input logic [DT_W-1:0] dt,
                         input logic signed [POS_W-1:0] opv);
        cmd           = c;
        elapsed       = dt;
        operand_value = opv;
        in_valid      = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(c, dt, opv);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid = 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 140)) @(negedge clk);
            else
                repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic drain_results();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // 31-bit registers ignore the top data bit, so it is random
    task automatic put_mag(input logic [CFG_IDX_W-1:0] idx, input logic [MAG_W-1:0] v);
        cfg_put(idx, {1'($urandom), v});
    endtask

    task automatic load_settings(input int kind);
        logic signed [POS_W-1:0] a, b, swap;
        logic [MAG_W-1:0]        vl, sd, ac, tl;
        a = $urandom;
        b = $urandom;
        if (a > b)
        begin
            swap = a;
            a = b;
            b = swap;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            a = RST_TARGET_MIN;
            b = RST_TARGET_MAX;
        end
        vl = MAG_W'($urandom_range(1 << 12, 1 << 24));
        sd = MAG_W'($urandom_range(1, 1 << 24));
        ac = MAG_W'($urandom_range(1 << 10, 1 << 26));
        tl = MAG_W'($urandom_range(0, 1 << 16));
        case (kind)
            1:
            begin
                a  = RST_TARGET_MIN;
                b  = RST_TARGET_MAX;
                vl = MAG_TOP;
                sd = 31'd1;
                ac = MAG_TOP;
                tl = '0;
            end
            2:
            begin
                vl = '0;
                sd = '0;
                ac = '0;
                tl = '0;
            end
            3:
            begin
                // crossed window: min above max
                a  = $urandom_range(1, 1 << 28);
                b  = -$signed($urandom_range(0, 1 << 28));
                tl = ($urandom_range(0, 1) == 0) ? MAG_TOP : tl;
            end
            4: sd = '0;
            default: ;
        endcase
        cfg_put(REG_TARGET_MIN, a);
        cfg_put(REG_TARGET_MAX, b);
        put_mag(REG_VELOCITY_LIMIT, vl);
        put_mag(REG_SLOWDOWN_DIST, sd);
        put_mag(REG_ACCELERATION, ac);
        put_mag(REG_ARRIVE_TOL, tl);
        cfg_put(($urandom_range(0, 1) == 0) ? REG_NONE_LO : REG_NONE_HI, $urandom);
    endtask

    function automatic logic signed [POS_W-1:0] pick_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 21)) - 32'sd1048576;
            2: return 32'sh7FFF_FFFF - $signed($urandom_range(0, 1 << 22));
            default: return 32'sh8000_0000 + $signed($urandom_range(0, 1 << 22));
        endcase
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'hFFFF;
            2, 3, 4: return DT_W'($urandom_range(1, 4096));
            default: return DT_W'($urandom);
        endcase
    endfunction

    // mostly set-position / set-target / tick runs, with some noise beats
    task automatic run_moves(input int count);
        int                      sent;
        int                      ticks;
        logic signed [POS_W-1:0] start;
        logic signed [POS_W-1:0] goal;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                start = pick_word();
                case ($urandom_range(0, 3))
                    0: goal = $urandom;
                    1: goal = start + $signed($urandom_range(0, 1 << 21)) - 32'sd1048576;
                    2: goal = start + $signed($urandom_range(0, 1 << 27)) - 32'sd67108864;
                    default: goal = ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF
                                                                : 32'sh8000_0000;
                endcase
                issue(CMD_SET_POSITION, DT_W'($urandom), start);
                issue(CMD_SET_TARGET, DT_W'($urandom), goal);
                ticks = $urandom_range(4, 40);
                repeat (ticks)
                begin
                    if ($urandom_range(0, 19) == 0)
                        issue(CMD_SET_TARGET, DT_W'($urandom), pick_word());
                    else
                        issue(CMD_TICK, pick_dt(), $urandom);
                end
                sent += ticks + 2;
            end
            else
            begin
                ticks = $urandom_range(1, 6);
                repeat (ticks)
                    issue(CMD_SPARE & 2'($urandom), DT_W'($urandom), $urandom);
                sent += ticks;
            end
            if ($urandom_range(0, 24) == 0)
                drain_results();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset defaults: zero elapsed, arrived, unused command, far targets
        issue(CMD_TICK, 16'h0000, 32'sh1234_5678);
        issue(CMD_TICK, 16'hFFFF, '0);
        issue(CMD_SPARE, 16'hFFFF, 32'sh5A5A_5A5A);
        issue(CMD_SET_TARGET, 16'h0000, 32'sh7FFF_FFFF);
        issue(CMD_TICK, 16'hFFFF, '0);
        issue(CMD_SET_TARGET, 16'h0000, 32'sh8000_0000);
        issue(CMD_TICK, 16'h8000, '0);
        issue(CMD_SET_POSITION, 16'h0000, 32'sh8000_0000);
        issue(CMD_SET_TARGET, 16'h0000, 32'sh7FFF_FFFF);
        issue(CMD_TICK, 16'hFFFF, '0);
        issue(CMD_SET_POSITION, 16'h0000, -32'sd327680);
        issue(CMD_SET_TARGET, 16'h0000, '0);
        repeat (3) issue(CMD_TICK, 16'hFFFF, '0);
        // distance exactly at the tolerance counts as reached
        issue(CMD_SET_POSITION, 16'h0000, 32'sd100);
        issue(CMD_SET_TARGET, 16'h0000, 32'sd6654);
        issue(CMD_TICK, 16'hFFFF, '0);
        drain_results();

        // full speed at once with zero slowdown distance, saturating both ends
        cfg_put(REG_TARGET_MIN, RST_TARGET_MIN);
        cfg_put(REG_TARGET_MAX, RST_TARGET_MAX);
        put_mag(REG_VELOCITY_LIMIT, MAG_TOP);
        put_mag(REG_SLOWDOWN_DIST, '0);
        put_mag(REG_ACCELERATION, MAG_TOP);
        put_mag(REG_ARRIVE_TOL, '0);
        issue(CMD_SET_POSITION, 16'h0000, 32'sh7FF0_0000);
        issue(CMD_SET_TARGET, 16'h0000, 32'sh7FFF_FFFF);
        issue(CMD_TICK, 16'hFFFF, '0);
        issue(CMD_SET_POSITION, 16'h0000, 32'sh8010_0000);
        issue(CMD_SET_TARGET, 16'h0000, 32'sh8000_0000);
        issue(CMD_TICK, 16'hFFFF, '0);
        drain_results();

        cfg_put(REG_TARGET_MIN, 32'sd6553600);
        cfg_put(REG_TARGET_MAX, -32'sd6553600);
        issue(CMD_SET_TARGET, 16'h0000, '0);
        issue(CMD_SET_TARGET, 16'h0000, -32'sd13107200);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                1: load_settings(1);
                3: load_settings(2);
                4: load_settings(3);
                5: load_settings(4);
                default: load_settings(0);
            endcase
            run_moves(RAND_ITEMS / PHASES);
            drain_results();
        end

        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS accel_limited_position_follower_core");
        else
            $display("FAIL accel_limited_position_follower_core");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/alpf_pkg.sv
hw/rtl/accel_limited_position_follower_core.sv
tb/tb.sv
